// ===== src/rpb_pkg.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel blend package
// Blend mode codes and the per-channel blend function.
// ----------------------------------------------------------------------------
package rpb_pkg;

	localparam logic [7:0] CH_MAX     = 8'd255;
	localparam logic [8:0] ALPHA_UNIT = 9'd256;

	typedef enum logic [2:0] {
		MODE_AVERAGE  = 3'd0,
		MODE_ALPHA    = 3'd1,
		MODE_ADD      = 3'd2,
		MODE_SUBTRACT = 3'd3,
		MODE_MULTIPLY = 3'd4,
		MODE_SCREEN   = 3'd5,
		MODE_LIGHTEN  = 3'd6,
		MODE_DARKEN   = 3'd7
	} blend_mode_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// w is the alpha weight src_alpha + 1
	function automatic logic [7:0] blend_channel(blend_mode_t mode, logic [7:0] s,
			logic [7:0] d, logic [8:0] w);
		logic [8:0]  sum9;
		logic [8:0]  v;
		logic [16:0] mix;
		logic [15:0] prod;
		logic [16:0] quot;
		logic [15:0] scr;
		logic [8:0]  scr_sum;
		logic [7:0]  res;
		sum9    = {1'b0, s} + {1'b0, d};
		v       = ALPHA_UNIT - w;
		mix     = 17'(w) * 17'(s) + 17'(v) * 17'(d);
		prod    = 16'(s) * 16'(d);
		// exact divide by 255 for products up to 255*255
		quot    = 17'(prod) + 17'(prod[15:8]) + 17'd1;
		scr     = 16'(d) * 16'(CH_MAX - s);
		scr_sum = {1'b0, scr[15:8]} + {1'b0, s};
		unique case (mode)
			MODE_AVERAGE:  res = sum9[8:1];
			MODE_ALPHA:    res = mix[15:8];
			MODE_ADD:      res = sum9[8] ? CH_MAX : sum9[7:0];
			MODE_SUBTRACT: res = (d > s) ? (d - s) : 8'd0;
			MODE_MULTIPLY: res = quot[15:8];
			MODE_SCREEN:   res = scr_sum[8] ? CH_MAX : scr_sum[7:0];
			MODE_LIGHTEN:  res = (s > d) ? s : d;
			MODE_DARKEN:   res = (s < d) ? s : d;
		endcase
		return res;
	endfunction

endpackage

// ===== src/rgba_pixel_blend_unit.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel blend unit
// Blends a source and a destination RGBA8888 pixel under one of eight modes.
// ----------------------------------------------------------------------------
// Takes one source/destination pixel pair per clock while the output is not
// stalled and returns one blended pixel per pair: the request lands in an
// input register, the per-channel blend logic runs in one pass, and the
// result sits in an output register until taken. While the output is stalled
// the input register still takes one request. The user must write blend_mode
// through cfg_we/cfg_wdata only while the unit is idle, which is not enforced.
module rgba_pixel_blend_unit
	import rpb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [31:0] m_tdata
);

	blend_mode_t blend_mode_q;
	logic        valid_s1;
	pixel_t      src_s1;
	pixel_t      dst_s1;
	logic        out_valid_q;
	pixel_t      out_pix_q;
	logic        out_free;
	logic        adv_s1;
	logic [8:0]  weight;
	logic [7:0]  src_a_eff;
	pixel_t      blend_pix;

	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= MODE_AVERAGE;
		end else if (cfg_we) begin
			blend_mode_q <= blend_mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			src_s1 <= pixel_t'({s_tdata[31:24], s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]});
			dst_s1 <= pixel_t'({s_tdata[63:56], s_tdata[55:48], s_tdata[47:40],
				s_tdata[39:32]});
		end
	end

	always_comb begin
		weight    = {1'b0, src_s1.alpha} + 9'd1;
		src_a_eff = (blend_mode_q == MODE_ALPHA) ? CH_MAX : src_s1.alpha;
		blend_pix.red   = blend_channel(blend_mode_q, src_s1.red, dst_s1.red, weight);
		blend_pix.green = blend_channel(blend_mode_q, src_s1.green, dst_s1.green, weight);
		blend_pix.blue  = blend_channel(blend_mode_q, src_s1.blue, dst_s1.blue, weight);
		blend_pix.alpha = blend_channel(blend_mode_q, src_a_eff, dst_s1.alpha, weight);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_pix_q <= blend_pix;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input register empty but request refused");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> m_tvalid)
		else $error("advanced pixel missing at output");

	a_lighten_max: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && blend_mode_q == MODE_LIGHTEN) |=>
		(m_tdata[7:0] >= $past(src_s1.red) && m_tdata[7:0] >= $past(dst_s1.red)))
		else $error("lighten result below an operand");

	a_darken_min: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && blend_mode_q == MODE_DARKEN) |=>
		(m_tdata[7:0] <= $past(src_s1.red) && m_tdata[7:0] <= $past(dst_s1.red)))
		else $error("darken result above an operand");
`endif

endmodule

// ===== tb/sv/rpb_blend_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGBA pixel blend checker
// Watches the configuration port and both stream channels of the blend unit.
// Every request taken on the input side is turned into the pixel that the
// current blend mode should give. That pixel is queued and compared channel
// by channel with the next pixel taken on the output side. Results that
// arrive with nothing queued and channels that differ are counted as
// failures. The number of queued pixels is reported back to the top level.
// ----------------------------------------------------------------------------
module rpb_blend_checker
	import rpb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	output int          pending,
	output int          fail_count
);

	blend_mode_t active_mode;
	logic [31:0] blended_q[$];
	logic [31:0] want;
	string       chan_name[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

	function automatic logic [31:0] blend_pixel(blend_mode_t mode, logic [63:0] req);
		logic [31:0] res;
		int          s;
		int          d;
		int          w;
		int          val;
		w = int'(req[31:24]) + 1;
		for (int k = 0; k < 4; k++) begin
			s = int'(req[8*k +: 8]);
			d = int'(req[32 + 8*k +: 8]);
			case (mode)
				MODE_AVERAGE: val = (s + d) / 2;
				MODE_ALPHA: begin
					if (k == 3)
						val = (w * 255 + (256 - w) * d) >> 8;
					else
						val = (w * s + (256 - w) * d) >> 8;
				end
				MODE_ADD: val = (s + d > 255) ? 255 : s + d;
				MODE_SUBTRACT: val = (d > s) ? d - s : 0;
				MODE_MULTIPLY: val = (s * d) / 255;
				MODE_SCREEN: begin
					val = ((d * (255 - s)) >> 8) + s;
					if (val > 255)
						val = 255;
				end
				MODE_LIGHTEN: val = (s > d) ? s : d;
				default: val = (s < d) ? s : d;
			endcase
			res[8*k +: 8] = val[7:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_mode = MODE_AVERAGE;
			blended_q.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (blended_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected pixel %h", $realtime, m_tdata);
				end else begin
					want = blended_q.pop_front();
					for (int k = 0; k < 4; k++) begin
						if (m_tdata[8*k +: 8] !== want[8*k +: 8]) begin
							fail_count++;
							if (fail_count <= 10)
								$display("%0t: %s expected %0d, got %0d", $realtime,
									chan_name[k], want[8*k +: 8], m_tdata[8*k +: 8]);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				blended_q.push_back(blend_pixel(active_mode, s_tdata));
			if (cfg_we)
				active_mode = blend_mode_t'(cfg_wdata);
			pending = blended_q.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGBA pixel blend unit testbench
// Drives source/destination pixel pairs into the blend unit under every
// blend mode: a short directed set of extreme pixels per mode, then random
// phases that each pick a mode and random sender gaps and receiver stalls.
// Pixel channels favor 0, 255 and values near them, and destination often
// equals source. The mode is only changed once all queued pixels are out.
// The last phase runs without any idling. A separate checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import rpb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1650;
	localparam int QUIET_ITEMS = 200;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	int          pending;
	int          fail_count;
	int          cycle_count = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          sent = 0;
	int          phase_len;

	rgba_pixel_blend_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	rpb_blend_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 3));
			3: return 8'($urandom_range(252, 254));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [63:0] pick_pixel_pair();
		logic [63:0] req;
		for (int k = 0; k < 8; k++)
			req[8*k +: 8] = pick_channel();
		if ($urandom_range(0, 7) == 0)
			req[63:32] = req[31:0];
		else if ($urandom_range(0, 3) == 0)
			req = {$urandom, $urandom};
		return req;
	endfunction

	// hold the request until taken, then advance to the next falling edge
	task automatic send_pixel(logic [63:0] req);
		if ($urandom_range(1, 100) <= gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= req;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// drain the pipeline, then write the mode
	task automatic set_mode(blend_mode_t mode);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	initial begin
		forever begin
			@(negedge clk);
			if ($urandom_range(1, 100) <= stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_pct = 20;
		stall_pct = 20;
		for (int m = 0; m < 8; m++) begin
			set_mode(blend_mode_t'(m));
			send_pixel({64{1'b1}});
			send_pixel({{32{1'b1}}, 32'h0});
			send_pixel({32'h0, {32{1'b1}}});
		end

		while (sent < RANDOM_ITEMS - QUIET_ITEMS) begin
			set_mode(blend_mode_t'($urandom_range(0, 7)));
			gap_pct = pick_idle_pct();
			stall_pct = pick_idle_pct();
			phase_len = $urandom_range(80, 160);
			for (int i = 0; i < phase_len; i++) begin
				send_pixel(pick_pixel_pair());
				sent++;
			end
		end

		set_mode(blend_mode_t'($urandom_range(0, 7)));
		gap_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < QUIET_ITEMS; i++)
			send_pixel(pick_pixel_pair());
		s_tvalid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
